FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that are suspended while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that also hold while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mtf_pkg.sv
`timescale 1ns / 1ps

package mtf_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam int DATA_W      = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_CLR = 2'd2,
		OP_QRY = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_REPORT
	} fsm_state_t;

	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic                     clr;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] minv;
	} cell_data_t;

endpackage

FILE: hdl/mtf_cell.sv
`timescale 1ns / 1ps

module mtf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mtf_pkg::cell_cmd_t  cmd,
	input  logic               prev_valid,
	input  mtf_pkg::cell_data_t nxt,
	output mtf_pkg::cell_data_t cur
);
	import mtf_pkg::*;

	// Each cell holds one item and the minimum of itself and every younger item.
	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] min_q;
	logic                     load;

	assign load = cmd.enq && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.deq) begin
			valid_q <= nxt.valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deq) begin
			value_q <= nxt.value;
			min_q   <= nxt.minv;
		end else if (load) begin
			value_q <= cmd.value;
			min_q   <= cmd.value;
		end else if (cmd.enq && valid_q && ($signed(cmd.value) < $signed(min_q))) begin
			min_q <= cmd.value;
		end
	end

	assign cur.valid = valid_q;
	assign cur.value = value_q;
	assign cur.minv  = min_q;

endmodule

FILE: hdl/min_tracking_fifo.sv
// First-in first-out queue of signed 64-bit items that also reports the minimum of everything
// it holds. Storage is a row of QUEUE_DEPTH cells; the head cell holds the oldest item, and every
// cell keeps the minimum of its own item and all younger ones, so the head cell carries the
// minimum of the whole queue. An enqueue loads the first free cell and folds the new item into
// every occupied cell's minimum; a dequeue shifts the row one place towards the head. Each command
// first updates the row, and the result is then formed from the updated head cell and the count. The
// next command is taken once the result has moved into the output register, so a stalled result
// holds off further commands. An enqueue into a full queue and a dequeue from an empty one leave
// the queue unchanged and report the matching status. No clearing pass follows reset.
`timescale 1ns / 1ps

module min_tracking_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [mtf_pkg::DATA_W-1:0]   value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [1:0]                          status,
	output logic signed [mtf_pkg::DATA_W-1:0]   popped_value,
	output logic signed [mtf_pkg::DATA_W-1:0]   oldest_value,
	output logic signed [mtf_pkg::DATA_W-1:0]   minimum_value,
	output logic [mtf_pkg::CNT_W-1:0]           occupancy,
	output logic                                is_empty
);
	import mtf_pkg::*;

	fsm_state_t               state_q;
	fsm_state_t               state_nxt;
	logic [CNT_W-1:0]         count_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] popped_q;
	logic                     res_valid_q;
	status_t                  res_status_q;
	logic signed [DATA_W-1:0] res_popped_q;
	logic signed [DATA_W-1:0] res_oldest_q;
	logic signed [DATA_W-1:0] res_min_q;
	logic [CNT_W-1:0]         res_count_q;
	logic                     fire;
	logic                     res_load;
	logic                     full;
	logic                     empty;
	cell_cmd_t                cmd;
	cell_data_t               cells [QUEUE_DEPTH];

	assign fire  = cmd_valid && !cmd_stall;
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd.enq   = fire && (opcode == OP_ENQ) && !full;
	assign cmd.deq   = fire && (opcode == OP_DEQ) && !empty;
	assign cmd.clr   = fire && (opcode == OP_CLR);
	assign cmd.value = value;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic       prv;
		cell_data_t nxt;

		if (g == 0) begin : g_head
			assign prv = 1'b1;
		end else begin : g_body
			assign prv = cells[g-1].valid;
		end

		if (g == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_link
			assign nxt = cells[g+1];
		end

		mtf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prv),
			.nxt        (nxt),
			.cur        (cells[g])
		);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					state_nxt = S_REPORT;
				end
			end
			S_REPORT: begin
				if (!res_valid_q || !res_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_stall = 1'b1;
		res_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
			end
			S_REPORT: begin
				res_load = !res_valid_q || !res_stall;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.enq) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.deq) begin
				count_q <= count_q - 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if ((opcode == OP_ENQ) && full) begin
				status_q <= ST_FULL;
			end else if ((opcode == OP_DEQ) && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
			popped_q <= cmd.deq ? cells[0].value : '0;
		end
		if (res_load) begin
			res_status_q <= status_q;
			res_popped_q <= popped_q;
			res_oldest_q <= empty ? '0 : cells[0].value;
			res_min_q    <= empty ? '0 : cells[0].minv;
			res_count_q  <= count_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = res_status_q;
	assign popped_value  = res_popped_q;
	assign oldest_value  = res_oldest_q;
	assign minimum_value = res_min_q;
	assign occupancy     = res_count_q;
	assign is_empty      = (res_count_q == '0);

endmodule

FILE: hdl/mtf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic [1:0]                        status,
	input logic signed [mtf_pkg::DATA_W-1:0] popped_value,
	input logic signed [mtf_pkg::DATA_W-1:0] oldest_value,
	input logic signed [mtf_pkg::DATA_W-1:0] minimum_value,
	input logic [mtf_pkg::CNT_W-1:0]         occupancy,
	input logic                              is_empty
);
	import mtf_pkg::*;

	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (res_valid !== 1'b1), "result shown during reset")

	`ASSERT_CLK(a_stall_hold, res_valid && res_stall |=> res_valid && $stable(status) && $stable(popped_value) && $stable(oldest_value) && $stable(minimum_value) && $stable(occupancy), "stalled item changed")

	`ASSERT_CLK(a_empty_flag, res_valid |-> (is_empty == (occupancy == '0)), "empty flag disagrees with occupancy")

	`ASSERT_CLK(a_empty_zero, res_valid && is_empty |-> (oldest_value == '0) && (minimum_value == '0), "empty queue reports non-zero front or minimum")

	`ASSERT_CLK(a_min_order, res_valid && !is_empty |-> (minimum_value <= oldest_value) && (status == ST_OK || status == ST_EMPTY || status == ST_FULL), "minimum above front or bad status")

endmodule

bind min_tracking_fifo mtf_checker u_mtf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.status        (status),
	.popped_value  (popped_value),
	.oldest_value  (oldest_value),
	.minimum_value (minimum_value),
	.occupancy     (occupancy),
	.is_empty      (is_empty)
);
